[rtl/wlm_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and the sine table generator of the wavetable LFO modulator.
package wlm_pkg;

	typedef enum logic [3:0] {
		MODE_CONST    = 4'd0,
		MODE_SINE     = 4'd1,
		MODE_TRIANGLE = 4'd2,
		MODE_SAW_UP   = 4'd3,
		MODE_SAW_DOWN = 4'd4,
		MODE_SQUARE   = 4'd5,
		MODE_SCALE    = 4'd6,
		MODE_BIAS     = 4'd7,
		MODE_ABS      = 4'd8,
		MODE_CLAMP    = 4'd9
	} wave_mode_t;

	typedef enum logic [2:0] {
		REG_WAVE_MODE    = 3'd0,
		REG_FREQUENCY    = 3'd1,
		REG_AMPLITUDE    = 3'd2,
		REG_PHASE_OFFSET = 3'd3,
		REG_PULSE_WIDTH  = 3'd4,
		REG_OPERAND_A    = 3'd5,
		REG_OPERAND_B    = 3'd6
	} reg_index_t;

	localparam longint unsigned PI_Q30 = 64'd3373259426;

	// Sine of entry i of a table with 2**lg entries, Q2.16, from a Taylor series in Q30.
	function automatic logic signed [17:0] sine_entry(int unsigned i, int unsigned lg);
		longint unsigned n;
		longint unsigned j;
		longint unsigned x;
		longint unsigned term;
		longint s;
		logic neg;
		n = 64'd1 << lg;
		neg = 1'b0;
		if (2 * longint'(i) > n) begin
			j = n - i;
			neg = 1'b1;
		end else begin
			j = i;
		end
		if (4 * j > n) begin
			x = (PI_Q30 * (n - 2 * j)) >> lg;
		end else begin
			x = (PI_Q30 * 2 * j) >> lg;
		end
		term = x;
		s = longint'(x);
		term = ((((term * x) >> 30) * x) >> 30) / 6;
		s = s - longint'(term);
		term = ((((term * x) >> 30) * x) >> 30) / 20;
		s = s + longint'(term);
		term = ((((term * x) >> 30) * x) >> 30) / 42;
		s = s - longint'(term);
		term = ((((term * x) >> 30) * x) >> 30) / 72;
		s = s + longint'(term);
		term = ((((term * x) >> 30) * x) >> 30) / 110;
		s = s - longint'(term);
		term = ((((term * x) >> 30) * x) >> 30) / 156;
		s = s + longint'(term);
		term = ((((term * x) >> 30) * x) >> 30) / 210;
		s = s - longint'(term);
		if (s < 0) begin
			s = 0;
		end
		s = (s + 8192) >>> 14;
		if (s > 65536) begin
			s = 65536;
		end
		return neg ? 18'(-s) : 18'(s);
	endfunction

endpackage

[rtl/wavetable_lfo_modulator.sv]
`timescale 1ns / 1ps
// Top level of the wavetable LFO modulator: configuration registers and result pipeline.
//
// The block takes one time sample in every clock cycle: a request is accepted whenever
// start is high, and busy stays low. Each request produces exactly one result, shown on
// value_out and saturated for one cycle with result_valid high. The result is computed
// in five register stages: the time products, the phase add with the registered sine
// table read, the interpolation product, the amplitude product and the output register.
// Results cannot be held off and must be captured in the cycle they are shown.
// Configuration writes take effect at once and are meant for times when no request is
// in flight.
module wavetable_lfo_modulator #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] time_in,
	output logic               result_valid,
	output logic signed [31:0] value_out,
	output logic               saturated,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	wlm_pkg::wave_mode_t wave_mode_q;
	logic signed [23:0]  frequency_q;
	logic signed [23:0]  amplitude_q;
	logic [15:0]         phase_offset_q;
	logic [16:0]         pulse_width_q;
	logic signed [31:0]  operand_a_q;
	logic signed [31:0]  operand_b_q;

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	logic [31:0]        tf_s1;
	logic signed [63:0] ta_s1;
	logic signed [31:0] t_s1;
	logic [31:0]        pos_s2;
	logic [32:0]        other_s2, other_s3, other_s4;
	logic signed [35:0] prod_s3;
	logic signed [17:0] v0_s3;
	logic signed [43:0] ap_s4;

	logic signed [55:0]  tf_full;
	logic signed [63:0]  ta_full;
	logic [31:0]         pos_c;
	logic [IDX_W-1:0]    addr0_c, addr1_c, idx0_c, idx1_c;
	logic signed [17:0]  sine0_c, sine1_c, v0_c, v1_c;
	logic signed [18:0]  diff_c;
	logic [15:0]         fr_c;
	logic signed [32:0]  bias_c, abs_c, t_ext_c;
	logic [32:0]         other_c, sq_c;
	logic signed [24:0]  amp_ext_c;
	logic signed [19:0]  interp_c;
	logic                table_mode;

	function automatic logic [32:0] sat48(logic signed [47:0] v);
		if (v > 48'sh0000_7FFF_FFFF) begin
			return {1'b1, 32'h7FFF_FFFF};
		end else if (v < -48'sh0000_8000_0000) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, v[31:0]};
	endfunction

	function automatic logic signed [17:0] calc_entry(wlm_pkg::wave_mode_t mode,
		logic [IDX_W-1:0] i);
		logic signed [IDX_W+1:0] d;
		logic signed [18:0]      m;
		logic signed [18:0]      r;
		d = $signed({1'b0, i, 1'b0}) - $signed((IDX_W+2)'(TABLE_DEPTH));
		if (d < 0) begin
			d = -d;
		end
		case (mode)
			wlm_pkg::MODE_TRIANGLE: begin
				m = 19'(d) <<< (17 - IDX_W);
				r = m - 19'sd65536;
			end
			wlm_pkg::MODE_SAW_UP: begin
				m = 19'($signed({1'b0, i})) <<< (17 - IDX_W);
				r = m - 19'sd65536;
			end
			default: begin
				m = 19'($signed({1'b0, i})) <<< (17 - IDX_W);
				r = 19'sd65536 - m;
			end
		endcase
		return 18'(r);
	endfunction

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q    <= wlm_pkg::MODE_CONST;
			frequency_q    <= 24'sd65536;
			amplitude_q    <= 24'sd65536;
			phase_offset_q <= 16'd0;
			pulse_width_q  <= 17'd32768;
			operand_a_q    <= 32'sd0;
			operand_b_q    <= 32'sd0;
		end else if (wr_en) begin
			unique case (wr_index)
				wlm_pkg::REG_WAVE_MODE:    wave_mode_q    <= wlm_pkg::wave_mode_t'(wr_data[3:0]);
				wlm_pkg::REG_FREQUENCY:    frequency_q    <= wr_data[23:0];
				wlm_pkg::REG_AMPLITUDE:    amplitude_q    <= wr_data[23:0];
				wlm_pkg::REG_PHASE_OFFSET: phase_offset_q <= wr_data[15:0];
				wlm_pkg::REG_PULSE_WIDTH:  pulse_width_q  <= wr_data[16:0];
				wlm_pkg::REG_OPERAND_A:    operand_a_q    <= wr_data;
				wlm_pkg::REG_OPERAND_B:    operand_b_q    <= wr_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (wave_mode_q) inside
			wlm_pkg::MODE_SINE, wlm_pkg::MODE_TRIANGLE, wlm_pkg::MODE_SAW_UP,
			wlm_pkg::MODE_SAW_DOWN: table_mode = 1'b1;
			default: table_mode = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			valid_s4     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			valid_s1     <= start;
			valid_s2     <= valid_s1;
			valid_s3     <= valid_s2;
			valid_s4     <= valid_s3;
			result_valid <= valid_s4;
		end
	end

	assign tf_full = 56'(time_in) * 56'(frequency_q);
	assign ta_full = 64'(time_in) * 64'(operand_a_q);

	always_ff @(posedge clk) begin
		t_s1  <= time_in;
		tf_s1 <= tf_full[31:0];
		ta_s1 <= ta_full;
	end

	assign pos_c   = tf_s1 + {phase_offset_q, 16'h0000};
	assign addr0_c = pos_c[31 -: IDX_W];
	assign addr1_c = addr0_c + IDX_W'(1);
	assign t_ext_c = 33'(t_s1);
	assign bias_c  = t_ext_c + 33'(operand_a_q);
	assign abs_c   = t_s1[31] ? -t_ext_c : t_ext_c;

	always_comb begin
		case (wave_mode_q)
			wlm_pkg::MODE_CONST: other_c = {1'b0, operand_a_q};
			wlm_pkg::MODE_SCALE: other_c = sat48(ta_s1[63:16]);
			wlm_pkg::MODE_BIAS:  other_c = sat48(48'(bias_c));
			wlm_pkg::MODE_ABS:   other_c = sat48(48'(abs_c));
			wlm_pkg::MODE_CLAMP: begin
				if (t_s1 < operand_a_q) begin
					other_c = {1'b0, operand_a_q};
				end else if (operand_b_q < t_s1) begin
					other_c = {1'b0, operand_b_q};
				end else begin
					other_c = {1'b0, t_s1};
				end
			end
			default: other_c = 33'd0;
		endcase
	end

	wlm_sine_rom #(
		.DEPTH(TABLE_DEPTH)
	) u_sine_rom (
		.clk   (clk),
		.addr_a(addr0_c),
		.addr_b(addr1_c),
		.data_a(sine0_c),
		.data_b(sine1_c)
	);

	always_ff @(posedge clk) begin
		pos_s2   <= pos_c;
		other_s2 <= other_c;
	end

	assign idx0_c    = pos_s2[31 -: IDX_W];
	assign idx1_c    = idx0_c + IDX_W'(1);
	assign fr_c      = pos_s2[31-IDX_W -: 16];
	assign v0_c      = (wave_mode_q == wlm_pkg::MODE_SINE) ? sine0_c
		: calc_entry(wave_mode_q, idx0_c);
	assign v1_c      = (wave_mode_q == wlm_pkg::MODE_SINE) ? sine1_c
		: calc_entry(wave_mode_q, idx1_c);
	assign diff_c    = 19'(v1_c) - 19'(v0_c);
	assign amp_ext_c = 25'(amplitude_q);
	assign sq_c      = ({1'b0, pos_s2} < {pulse_width_q, 16'h0000})
		? {1'b0, 32'(amp_ext_c)} : {1'b0, 32'(-amp_ext_c)};

	always_ff @(posedge clk) begin
		prod_s3  <= 36'(diff_c) * 36'($signed({1'b0, fr_c}));
		v0_s3    <= v0_c;
		other_s3 <= (wave_mode_q == wlm_pkg::MODE_SQUARE) ? sq_c : other_s2;
	end

	assign interp_c = 20'(v0_s3) + prod_s3[35:16];

	always_ff @(posedge clk) begin
		ap_s4    <= 44'(amplitude_q) * 44'(interp_c);
		other_s4 <= other_s3;
	end

	always_ff @(posedge clk) begin
		if (table_mode) begin
			value_out <= 32'($signed(ap_s4[43:16]));
			saturated <= 1'b0;
		end else begin
			value_out <= other_s4[31:0];
			saturated <= other_s4[32];
		end
	end

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 result_valid)
		else $error("accepted request produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start, 5))
		else $error("result without a matching request");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |->
		(value_out == 32'sh7FFF_FFFF) || (value_out == -32'sh8000_0000))
		else $error("saturated flag with an unclipped value");

endmodule

[rtl/wlm_sine_rom.sv]
`timescale 1ns / 1ps
// Dual-read sine table with registered outputs.
module wlm_sine_rom #(
	parameter int DEPTH = 1024
) (
	input  logic                       clk,
	input  logic [$clog2(DEPTH)-1:0]   addr_a,
	input  logic [$clog2(DEPTH)-1:0]   addr_b,
	output logic signed [17:0]         data_a,
	output logic signed [17:0]         data_b
);

	localparam int ADDR_W = $clog2(DEPTH);

	logic signed [17:0] rom_c [DEPTH];

	for (genvar g = 0; g < DEPTH; g++) begin : g_rom
		assign rom_c[g] = wlm_pkg::sine_entry(g, ADDR_W);
	end

	always_ff @(posedge clk) begin
		data_a <= rom_c[addr_a];
		data_b <= rom_c[addr_b];
	end

endmodule

[bench/wavetable_lfo_modulator_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the wavetable LFO modulator with directed and random requests.
module wavetable_lfo_modulator_tb;

	localparam int DEPTH = 1024;
	localparam int LATENCY = 5;
	localparam int STALL_LIMIT = 2000;
	localparam logic [3:0] MODE_SPARE_FIRST = 4'd10;
	localparam logic [3:0] MODE_SPARE_LAST = 4'd15;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] value;
		logic               sat;
	} lfo_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] time_in = '0;
	logic               result_valid;
	logic signed [31:0] value_out;
	logic               saturated;
	logic               wr_en = 1'b0;
	logic [2:0]         wr_index = '0;
	logic [31:0]        wr_data = '0;

	logic [3:0]         cfg_mode = 4'd0;
	logic signed [23:0] cfg_freq = 24'sd65536;
	logic signed [23:0] cfg_amp = 24'sd65536;
	logic [15:0]        cfg_phase = 16'd0;
	logic [16:0]        cfg_pw = 17'd32768;
	logic signed [31:0] cfg_a = '0;
	logic signed [31:0] cfg_b = '0;

	longint      sine_rom [DEPTH];
	lfo_result_t expected_results [$];
	int          errors = 0;
	int          idle_pct = 0;
	int          stall_cycles = 0;

	wavetable_lfo_modulator #(.TABLE_DEPTH(DEPTH)) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.time_in      (time_in),
		.result_valid (result_valid),
		.value_out    (value_out),
		.saturated    (saturated),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic longint sine_sample(int unsigned i);
		longint unsigned n;
		longint unsigned j;
		longint unsigned x;
		longint unsigned term;
		longint acc;
		logic neg;
		n = DEPTH;
		neg = (2 * longint'(i) > n);
		j = neg ? n - i : i;
		if (4 * j > n) begin
			x = (wlm_pkg::PI_Q30 * (n - 2 * j)) / n;
		end else begin
			x = (wlm_pkg::PI_Q30 * 2 * j) / n;
		end
		term = x;
		acc = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			term = ((((term * x) >> 30) * x) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		acc = (acc + 8192) >>> 14;
		if (acc > 65536) begin
			acc = 65536;
		end
		return neg ? -acc : acc;
	endfunction

	function automatic longint wave_entry(logic [3:0] mode, int i);
		longint d;
		case (mode)
			wlm_pkg::MODE_SINE: begin
				return sine_rom[i];
			end
			wlm_pkg::MODE_TRIANGLE: begin
				d = 2 * i - DEPTH;
				if (d < 0) begin
					d = -d;
				end
				return (d * 131072) / DEPTH - 65536;
			end
			wlm_pkg::MODE_SAW_UP: begin
				return (longint'(i) * 131072) / DEPTH - 65536;
			end
			default: begin
				return 65536 - (longint'(i) * 131072) / DEPTH;
			end
		endcase
	endfunction

	function automatic lfo_result_t predict_lfo(logic signed [31:0] t_in);
		longint t;
		longint f;
		longint amp;
		longint a;
		longint b;
		longint v;
		longint v0;
		longint v1;
		longint interp;
		longint fr;
		longint pos_l;
		longint pw_l;
		logic [31:0] pos;
		int idx;
		int idx1;
		lfo_result_t r;
		t = t_in;
		f = cfg_freq;
		amp = cfg_amp;
		a = cfg_a;
		b = cfg_b;
		pos = 32'(t * f + (longint'(cfg_phase) << 16));
		pos_l = pos;
		pw_l = cfg_pw;
		case (cfg_mode) inside
			wlm_pkg::MODE_SINE, wlm_pkg::MODE_TRIANGLE, wlm_pkg::MODE_SAW_UP,
			wlm_pkg::MODE_SAW_DOWN: begin
				idx = pos[31:22];
				idx1 = (idx + 1) % DEPTH;
				fr = pos[21:6];
				v0 = wave_entry(cfg_mode, idx);
				v1 = wave_entry(cfg_mode, idx1);
				interp = v0 + (((v1 - v0) * fr) >>> 16);
				v = (amp * interp) >>> 16;
			end
			wlm_pkg::MODE_CONST: v = a;
			wlm_pkg::MODE_SQUARE: v = (pos_l < (pw_l << 16)) ? amp : -amp;
			wlm_pkg::MODE_SCALE: v = (t * a) >>> 16;
			wlm_pkg::MODE_BIAS: v = t + a;
			wlm_pkg::MODE_ABS: v = (t < 0) ? -t : t;
			wlm_pkg::MODE_CLAMP: v = (t < a) ? a : ((b < t) ? b : t);
			default: v = 0;
		endcase
		r.sat = 1'b0;
		if (v > Q_MAX) begin
			r.sat = 1'b1;
			v = Q_MAX;
		end else if (v < Q_MIN) begin
			r.sat = 1'b1;
			v = Q_MIN;
		end
		r.value = 32'(v);
		return r;
	endfunction

	task automatic wait_idle();
		start <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 1) @(posedge clk);
	endtask

	task automatic write_reg(wlm_pkg::reg_index_t idx, logic [31:0] data);
		if (start || expected_results.size() != 0) begin
			wait_idle();
		end
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		case (idx)
			wlm_pkg::REG_WAVE_MODE: cfg_mode = data[3:0];
			wlm_pkg::REG_FREQUENCY: cfg_freq = data[23:0];
			wlm_pkg::REG_AMPLITUDE: cfg_amp = data[23:0];
			wlm_pkg::REG_PHASE_OFFSET: cfg_phase = data[15:0];
			wlm_pkg::REG_PULSE_WIDTH: cfg_pw = data[16:0];
			wlm_pkg::REG_OPERAND_A: cfg_a = data;
			wlm_pkg::REG_OPERAND_B: cfg_b = data;
			default: ;
		endcase
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_time(logic signed [31:0] t);
		start <= 1'b1;
		time_in <= t;
		do @(posedge clk); while (busy);
		expected_results = {expected_results, predict_lfo(t)};
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	function automatic logic [31:0] rand_signed(int w);
		logic [31:0] r;
		case ($urandom_range(7)) inside
			0: r = (32'h1 << (w - 1)) - 1;
			1: r = ~((32'h1 << (w - 1)) - 1);
			2: r = '0;
			3, 4: r = $urandom_range(32'h3FFFF) - 32'h20000;
			default: begin
				r = $urandom;
				r = 32'($signed(r << (32 - w)) >>> (32 - w));
			end
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rand_time();
		case ($urandom_range(3)) inside
			0, 1: return $urandom;
			2: return $urandom_range(32'hFFFFF) - 32'h80000;
			default: begin
				case ($urandom_range(4))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'hFFFF_FFFF;
					default: return 32'h0000_0001;
				endcase
			end
		endcase
	endfunction

	task automatic randomize_config();
		logic [31:0] mode;
		logic [31:0] pw;
		logic [31:0] phase;
		if ($urandom_range(9) == 0) begin
			mode = $urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST);
		end else begin
			mode = $urandom_range(wlm_pkg::MODE_CLAMP, wlm_pkg::MODE_CONST);
		end
		case ($urandom_range(5))
			0: pw = 32'd0;
			1: pw = 32'd65536;
			2: pw = 32'd65535;
			3: pw = $urandom_range(32'h1FFFF);
			default: pw = $urandom_range(32'd65536);
		endcase
		case ($urandom_range(3))
			0: phase = 32'd0;
			1: phase = 32'd65535;
			default: phase = $urandom_range(32'd65535);
		endcase
		write_reg(wlm_pkg::REG_WAVE_MODE, mode);
		write_reg(wlm_pkg::REG_FREQUENCY, rand_signed(24));
		write_reg(wlm_pkg::REG_AMPLITUDE, rand_signed(24));
		write_reg(wlm_pkg::REG_PHASE_OFFSET, phase);
		write_reg(wlm_pkg::REG_PULSE_WIDTH, pw);
		write_reg(wlm_pkg::REG_OPERAND_A, rand_signed(32));
		write_reg(wlm_pkg::REG_OPERAND_B, rand_signed(32));
	endtask

	// Runs on the reset values, including the wrap of negative time and of the table end.
	task automatic test_reset_defaults();
		send_time(32'h0000_0000);
		write_reg(wlm_pkg::REG_WAVE_MODE, 32'(wlm_pkg::MODE_SINE));
		send_time(32'h0000_4000);
		send_time(32'hFFFF_C000);
		send_time(32'h0000_FFFF);
		write_reg(wlm_pkg::REG_WAVE_MODE, 32'(wlm_pkg::MODE_SQUARE));
		send_time(32'h0000_2000);
		send_time(32'h0000_C000);
	endtask

	task automatic test_square_width();
		write_reg(wlm_pkg::REG_PULSE_WIDTH, 32'd65536);
		send_time(32'h0000_FFFF);
		write_reg(wlm_pkg::REG_PULSE_WIDTH, 32'd0);
		write_reg(wlm_pkg::REG_AMPLITUDE, 32'hFF80_0000);
		send_time(32'h0000_0000);
		write_reg(wlm_pkg::REG_PULSE_WIDTH, 32'h0001_FFFF);
		send_time(32'h0000_FFFF);
	endtask

	task automatic test_table_extremes();
		write_reg(wlm_pkg::REG_AMPLITUDE, 32'h007F_FFFF);
		write_reg(wlm_pkg::REG_FREQUENCY, 32'hFF80_0000);
		write_reg(wlm_pkg::REG_PHASE_OFFSET, 32'h0000_FFFF);
		for (int m = wlm_pkg::MODE_TRIANGLE; m <= wlm_pkg::MODE_SAW_DOWN; m++) begin
			write_reg(wlm_pkg::REG_WAVE_MODE, 32'(m));
			send_time(32'h7FFF_FFFF);
			send_time(32'h8000_0000);
		end
	endtask

	task automatic test_arith_saturation();
		write_reg(wlm_pkg::REG_WAVE_MODE, 32'(wlm_pkg::MODE_SCALE));
		write_reg(wlm_pkg::REG_OPERAND_A, 32'h7FFF_FFFF);
		send_time(32'h7FFF_FFFF);
		send_time(32'h8000_0000);
		write_reg(wlm_pkg::REG_WAVE_MODE, 32'(wlm_pkg::MODE_BIAS));
		send_time(32'h7FFF_FFFF);
		write_reg(wlm_pkg::REG_OPERAND_A, 32'h8000_0000);
		send_time(32'h8000_0000);
		write_reg(wlm_pkg::REG_WAVE_MODE, 32'(wlm_pkg::MODE_ABS));
		send_time(32'h8000_0000);
		send_time(32'hFFFF_FFFB);
	endtask

	// Clamp with the minimum above the maximum, a constant, and the unassigned modes.
	task automatic test_clamp_const_spare();
		write_reg(wlm_pkg::REG_WAVE_MODE, 32'(wlm_pkg::MODE_CLAMP));
		write_reg(wlm_pkg::REG_OPERAND_A, 32'h000A_0000);
		write_reg(wlm_pkg::REG_OPERAND_B, 32'hFFF6_0000);
		send_time(32'h0000_0000);
		write_reg(wlm_pkg::REG_OPERAND_A, 32'hFFFB_0000);
		write_reg(wlm_pkg::REG_OPERAND_B, 32'h0005_0000);
		send_time(32'h0064_0000);
		write_reg(wlm_pkg::REG_WAVE_MODE, 32'(wlm_pkg::MODE_CONST));
		write_reg(wlm_pkg::REG_OPERAND_A, 32'h8000_0000);
		send_time(32'h0000_0001);
		write_reg(wlm_pkg::REG_WAVE_MODE, 32'(MODE_SPARE_FIRST));
		send_time(32'h7FFF_FFFF);
		write_reg(wlm_pkg::REG_WAVE_MODE, 32'(MODE_SPARE_LAST));
		send_time(32'h7FFF_FFFF);
	endtask

	task automatic test_random_traffic(int idle, int items);
		int sent;
		int burst;
		idle_pct = idle;
		sent = 0;
		while (sent < items) begin
			randomize_config();
			burst = $urandom_range(90, 20);
			for (int k = 0; k < burst && sent < items; k++) begin
				send_time(rand_time());
				sent++;
			end
		end
		wait_idle();
	endtask

	always @(posedge clk) begin
		lfo_result_t want;
		if (result_valid) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual value_out %h saturated %b",
					$time, value_out, saturated);
			end else begin
				want = expected_results.pop_front();
				if (value_out !== want.value) begin
					errors++;
					$display("%0t: value_out expected %h actual %h", $time, want.value, value_out);
				end
				if (saturated !== want.sat) begin
					errors++;
					$display("%0t: saturated expected %b actual %b", $time, want.sat, saturated);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || wr_en) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("wavetable_lfo_modulator_tb failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			sine_rom[i] = sine_sample(i);
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_square_width();
		test_table_extremes();
		test_arith_saturation();
		test_clamp_const_spare();
		test_random_traffic(0, 700);
		test_random_traffic(75, 550);
		test_random_traffic(12, 700);
		wait_idle();
		if (errors == 0) begin
			$display("wavetable_lfo_modulator_tb passed");
		end else begin
			$display("wavetable_lfo_modulator_tb failed");
		end
		$finish;
	end

endmodule
